[rtl/core/rmst_pkg.sv]
// shared types and constants of the range maximum segment tree
package rmst_pkg;

  localparam int IDX_W = 16;
  localparam int VAL_W = 32;

  localparam int DEFAULT_LEAVES      = 65536;
  localparam int DEFAULT_QUEUE_DEPTH = 2;

  // minus infinity of the tree
  localparam logic signed [VAL_W-1:0] SENTINEL = -32'sd1000000000;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_QUERY,
    KIND_EMPTY
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic [IDX_W-1:0]         first;
    logic [IDX_W-1:0]         last;
    logic signed [VAL_W-1:0]  value;
  } item_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP,
    ST_QRUN
  } bk_state_e;

endpackage

[rtl/core/rmst_front.sv]
// front end: takes commands, drops stray writes, classifies queries
module rmst_front #(
  parameter int LEAVES = rmst_pkg::DEFAULT_LEAVES
) (
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic [rmst_pkg::IDX_W-1:0]        first_index_i,
  input  logic [rmst_pkg::IDX_W-1:0]        last_index_i,
  input  logic signed [rmst_pkg::VAL_W-1:0] new_value_i,
  input  logic                              queue_full_i,
  input  logic                              clearing_i,
  output logic                              push_o,
  output rmst_pkg::item_t                   item_o
);
  import rmst_pkg::*;

  localparam int LW = $clog2(LEAVES);
  localparam int CW = ((LW > IDX_W) ? LW : IDX_W) + 1;
  localparam logic [CW-1:0] LEAVES_C = CW'(LEAVES);
  localparam logic [CW-1:0] LAST_C   = CW'(LEAVES - 1);

  logic          accept;
  logic          in_range;
  logic [CW-1:0] first_ext;
  logic [CW-1:0] last_ext;
  logic [CW-1:0] last_sat;

  assign busy   = queue_full_i | clearing_i;
  assign accept = start & ~busy;

  always_comb begin
    first_ext = CW'(first_index_i);
    last_ext  = CW'(last_index_i);
    in_range  = first_ext < LEAVES_C;
    last_sat  = (last_ext > LAST_C) ? LAST_C : last_ext;

    item_o.first = first_index_i;
    item_o.last  = IDX_W'(last_sat);
    item_o.value = new_value_i;
    if (op_i == OP_WRITE) begin
      item_o.kind = KIND_UPDATE;
    end else if (!in_range || (first_ext > last_sat)) begin
      item_o.kind = KIND_EMPTY;
    end else begin
      item_o.kind = KIND_QUERY;
    end

    // writes beyond the leaves vanish here
    push_o = accept && ((op_i == OP_QUERY) || in_range);
  end

endmodule

[rtl/core/rmst_queue.sv]
// small fifo of classified items between front and back
module rmst_queue #(
  parameter int DEPTH = rmst_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rmst_pkg::item_t item_i,
  input  logic            pop_i,
  output rmst_pkg::item_t item_o,
  output logic            full_o,
  output logic            empty_o
);
  import rmst_pkg::*;

  localparam int QW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t         slot_q [DEPTH];
  logic [QW-1:0] wr_q, wr_d;
  logic [QW-1:0] rd_q, rd_d;
  logic [QW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (QW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign item_o  = slot_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QW'(DEPTH - 1)) ? '0 : wr_q + QW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == QW'(DEPTH - 1)) ? '0 : rd_q + QW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (QW+1)'(1);
      2'b01:   cnt_d = cnt_q - (QW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= item_i;
    end
  end

endmodule

[rtl/core/rmst_back.sv]
// back end: node memory, clearing pass, update climb and query walk
module rmst_back #(
  parameter int LEAVES = rmst_pkg::DEFAULT_LEAVES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rmst_pkg::item_t                   item_i,
  input  logic                              avail_i,
  output logic                              pop_o,
  output logic                              clearing_o,
  output logic                              done_o,
  output logic signed [rmst_pkg::VAL_W-1:0] max_value_o,
  output logic                              empty_range_o
);
  import rmst_pkg::*;

  localparam int LW = $clog2(LEAVES);
  localparam int NW = LW + 1;
  localparam int HW = NW + 1;
  localparam int NODES = 2 ** NW;

  bk_state_e state_q, state_d;

  logic signed [VAL_W-1:0] tree_q [NODES];
  logic signed [VAL_W-1:0] rd_a_q, rd_b_q;

  logic                    mem_we;
  logic [NW-1:0]           mem_waddr;
  logic signed [VAL_W-1:0] mem_wdata;
  logic [NW-1:0]           rd_addr_a, rd_addr_b;

  logic [NW-1:0]           clr_q, clr_d;
  logic [NW-1:0]           node_q, node_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [HW-1:0]           lo_q, lo_d;
  logic [HW-1:0]           hi_q, hi_d;
  logic signed [VAL_W-1:0] acc_q, acc_d;
  logic                    pa_q, pa_d;
  logic                    pb_q, pb_d;
  logic                    done_q, done_d;
  logic signed [VAL_W-1:0] max_q, max_d;
  logic                    empty_q, empty_d;

  logic [NW-1:0]           leaf_node;
  logic [NW-1:0]           parent;
  logic signed [VAL_W-1:0] up_max;
  logic signed [VAL_W-1:0] acc_1, acc_2;
  logic                    run;
  logic                    at_root;
  logic                    clr_last;

  assign clearing_o    = state_q == ST_CLEAR;
  assign done_o        = done_q;
  assign max_value_o   = max_q;
  assign empty_range_o = empty_q;

  always_comb begin
    leaf_node = {1'b1, LW'(item_i.first)};
    parent    = node_q >> 1;
    at_root   = parent == NW'(1);
    up_max    = (rd_a_q > val_q) ? rd_a_q : val_q;
    run       = lo_q < hi_q;
    clr_last  = clr_q == '1;
    // fold the nodes read in the previous cycle
    acc_1     = (pa_q && (rd_a_q > acc_q)) ? rd_a_q : acc_q;
    acc_2     = (pb_q && (rd_b_q > acc_1)) ? rd_b_q : acc_1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (avail_i) begin
          case (item_i.kind)
            KIND_UPDATE: state_d = ST_UP;
            KIND_QUERY:  state_d = ST_QRUN;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_UP: begin
        if (at_root) state_d = ST_IDLE;
      end
      ST_QRUN: begin
        if (!run) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = SENTINEL;
    rd_addr_a = '0;
    rd_addr_b = '0;
    pop_o     = 1'b0;
    clr_d     = clr_q;
    node_d    = node_q;
    val_d     = val_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    acc_d     = acc_q;
    pa_d      = 1'b0;
    pb_d      = 1'b0;
    done_d    = 1'b0;
    max_d     = max_q;
    empty_d   = empty_q;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + NW'(1);
      end
      ST_IDLE: begin
        if (avail_i) begin
          pop_o = 1'b1;
          case (item_i.kind)
            KIND_UPDATE: begin
              // write the leaf and fetch its sibling
              mem_we    = 1'b1;
              mem_waddr = leaf_node;
              mem_wdata = item_i.value;
              rd_addr_a = leaf_node ^ NW'(1);
              node_d    = leaf_node;
              val_d     = item_i.value;
            end
            KIND_QUERY: begin
              lo_d  = HW'(leaf_node);
              hi_d  = HW'({1'b1, LW'(item_i.last)}) + HW'(1);
              acc_d = SENTINEL;
            end
            default: begin
              done_d  = 1'b1;
              max_d   = SENTINEL;
              empty_d = 1'b1;
            end
          endcase
        end
      end
      ST_UP: begin
        // one tree level per cycle: write parent, fetch parent's sibling
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = up_max;
        rd_addr_a = parent ^ NW'(1);
        node_d    = parent;
        val_d     = up_max;
      end
      ST_QRUN: begin
        acc_d = acc_2;
        if (run) begin
          pa_d      = lo_q[0];
          pb_d      = hi_q[0];
          rd_addr_a = lo_q[NW-1:0];
          rd_addr_b = NW'(hi_q - HW'(1));
          lo_d      = (lo_q + HW'(lo_q[0])) >> 1;
          hi_d      = hi_q >> 1;
        end else begin
          done_d  = 1'b1;
          max_d   = acc_2;
          empty_d = 1'b0;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      pa_q    <= 1'b0;
      pb_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pa_q    <= pa_d;
      pb_q    <= pb_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    val_q   <= val_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    acc_q   <= acc_d;
    max_q   <= max_d;
    empty_q <= empty_d;
  end

  // node store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tree_q[mem_waddr] <= mem_wdata;
    end
    rd_a_q <= tree_q[rd_addr_a];
    rd_b_q <= tree_q[rd_addr_b];
  end

endmodule

[rtl/core/range_max_segment_tree.sv]
// top level of the range maximum segment tree
//
// range maximum over LEAVES signed 32-bit leaves with single-leaf writes.
// a command is taken when start is high and busy is low; the front end
// classifies it and drops writes to leaves beyond the tree, then a two-entry
// queue hands it to the back end, so start can be taken while the back end
// still works on an earlier item. after reset the back end runs a clearing
// pass over the node memory, with busy held high, that sets every node to
// -1000000000. a write in the back end climbs from the leaf to the root a
// level at a time, since the node memory has a single write port. a query
// pops its item, then walks up the tree reading up to two nodes per level
// on the two read ports, and then folds the last reads. an empty or reversed
// range answers in the cycle after its pop with the sentinel and
// empty_range_o set. each query result is shown for exactly one cycle with
// done_o high and there is no way to stall it: the receiver must take every
// transfer.
module range_max_segment_tree #(
  parameter int LEAVES      = rmst_pkg::DEFAULT_LEAVES,
  parameter int QUEUE_DEPTH = rmst_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              op_i,
  input  logic [rmst_pkg::IDX_W-1:0]        first_index_i,
  input  logic [rmst_pkg::IDX_W-1:0]        last_index_i,
  input  logic signed [rmst_pkg::VAL_W-1:0] new_value_i,
  output logic                              done_o,
  output logic signed [rmst_pkg::VAL_W-1:0] max_value_o,
  output logic                              empty_range_o
);
  import rmst_pkg::*;

  // front to queue
  logic  push;
  item_t push_item;
  // queue to back
  item_t head_item;
  logic  queue_full;
  logic  queue_empty;
  logic  pop;
  // back end status, holds off commands during the clearing pass
  logic  clearing;

  rmst_front #(
    .LEAVES (LEAVES)
  ) u_front (
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .first_index_i (first_index_i),
    .last_index_i  (last_index_i),
    .new_value_i   (new_value_i),
    .queue_full_i  (queue_full),
    .clearing_i    (clearing),
    .push_o        (push),
    .item_o        (push_item)
  );

  rmst_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .full_o  (queue_full),
    .empty_o (queue_empty)
  );

  rmst_back #(
    .LEAVES (LEAVES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (head_item),
    .avail_i       (~queue_empty),
    .pop_o         (pop),
    .clearing_o    (clearing),
    .done_o        (done_o),
    .max_value_o   (max_value_o),
    .empty_range_o (empty_range_o)
  );

endmodule

[test/range_max_segment_tree_tb.sv]
// self-checking testbench of the range maximum segment tree, directed and random traffic
module range_max_segment_tree_tb;

  import rmst_pkg::*;

  localparam int LEAVES = DEFAULT_LEAVES;
  localparam int NODES = 2 * LEAVES;
  // settle time given to the back end once every answer is in
  localparam int SETTLE_CYCLES = 64;
  // the clearing pass after reset alone keeps busy high, so the limit scales with NODES
  localparam int WATCHDOG_LIMIT = 4 * NODES + 100000;
  localparam int RANDOM_PER_PHASE = 210;
  localparam int HOT_SPAN = 64;

  // one answer as the block should report it
  typedef struct {
    logic signed [VAL_W-1:0] max_value;
    logic                    empty;
  } answer_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic                    op_i;
  logic [IDX_W-1:0]        first_index_i;
  logic [IDX_W-1:0]        last_index_i;
  logic signed [VAL_W-1:0] new_value_i;
  logic                    done_o;
  logic signed [VAL_W-1:0] max_value_o;
  logic                    empty_range_o;

  // mirror of the node memory, node 1 is the root and leaf j sits at node LEAVES+j
  logic signed [VAL_W-1:0] node_max [1:NODES-1];
  answer_t                 pending_answers [$];

  int error_count;
  int write_count;
  int query_count;
  int empty_count;
  int answer_count;
  int quiet_cycles;
  int idle_pct;
  int hot_base;

  range_max_segment_tree dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .first_index_i (first_index_i),
    .last_index_i  (last_index_i),
    .new_value_i   (new_value_i),
    .done_o        (done_o),
    .max_value_o   (max_value_o),
    .empty_range_o (empty_range_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // mirror of the tree
  // ---------------------------------------------------------------------------

  function automatic void clear_tree();
    for (int n = 1; n < NODES; n++) begin
      node_max[n] = SENTINEL;
    end
  endfunction

  // write one leaf and refold every ancestor up to the root
  function automatic void tree_write_leaf(int unsigned leaf, logic signed [VAL_W-1:0] value);
    int unsigned p;
    p = leaf + LEAVES;
    node_max[p] = value;
    while (p > 1) begin
      p = p >> 1;
      node_max[p] = (node_max[2*p] > node_max[2*p+1]) ? node_max[2*p] : node_max[2*p+1];
    end
  endfunction

  // bottom-up walk over the inclusive leaf range, the accumulator starts at minus infinity
  function automatic logic signed [VAL_W-1:0] tree_range_max(int unsigned lo_leaf,
                                                             int unsigned hi_leaf);
    logic signed [VAL_W-1:0] acc;
    int unsigned lo;
    int unsigned hi;
    acc = SENTINEL;
    lo = lo_leaf + LEAVES;
    hi = hi_leaf + LEAVES + 1;
    while (lo < hi) begin
      if ((lo & 1) != 0) begin
        if (node_max[lo] > acc) acc = node_max[lo];
        lo++;
      end
      if ((hi & 1) != 0) begin
        hi--;
        if (node_max[hi] > acc) acc = node_max[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return acc;
  endfunction

  // apply one accepted command to the mirror and queue the answer it owes, if any
  function automatic void predict_command(logic op, logic [IDX_W-1:0] first,
                                          logic [IDX_W-1:0] last,
                                          logic signed [VAL_W-1:0] value);
    int unsigned lo;
    int unsigned hi;
    answer_t     ans;
    lo = 32'(first);
    hi = 32'(last);
    if (op == OP_WRITE) begin
      // writes past the last leaf are dropped
      if (lo < LEAVES) tree_write_leaf(lo, value);
      write_count++;
      return;
    end
    query_count++;
    // the top of the range saturates at the last leaf
    if (hi >= LEAVES) hi = LEAVES - 1;
    if (lo >= LEAVES || lo > hi) begin
      ans.max_value = SENTINEL;
      ans.empty = 1'b1;
    end else begin
      ans.max_value = tree_range_max(lo, hi);
      ans.empty = 1'b0;
    end
    pending_answers.push_back(ans);
  endfunction

  // ---------------------------------------------------------------------------
  // monitor, checker and watchdog, all on the rising edge
  // ---------------------------------------------------------------------------

  // the answer is checked before a command accepted at the same edge is queued;
  // an answer can never belong to a command taken at the same edge
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni === 1'b1) begin
      quiet_cycles++;
      if (done_o === 1'b1) begin
        quiet_cycles = 0;
        answer_count++;
        if (pending_answers.size() == 0) begin
          error_count++;
          $display("%0t: unexpected answer: expected none, actual max %0d empty %b",
                   $time, max_value_o, empty_range_o);
        end else begin
          want = pending_answers.pop_front();
          if (want.empty) empty_count++;
          if (max_value_o !== want.max_value) begin
            error_count++;
            $display("%0t: max_value mismatch: expected %0d, actual %0d",
                     $time, want.max_value, max_value_o);
          end
          if (empty_range_o !== want.empty) begin
            error_count++;
            $display("%0t: empty_range mismatch: expected %b, actual %b",
                     $time, want.empty, empty_range_o);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        quiet_cycles = 0;
        predict_command(op_i, first_index_i, last_index_i, new_value_i);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog: no transfer for %0d cycles", $time, quiet_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // send one command; start stays high into the next command when no gap is drawn,
  // so it is never lowered and raised in the same step
  task automatic send_command(logic op, logic [IDX_W-1:0] first, logic [IDX_W-1:0] last,
                              logic signed [VAL_W-1:0] value);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start         <= 1'b1;
    op_i          <= op;
    first_index_i <= first;
    last_index_i  <= last;
    new_value_i   <= value;
    // accepted at the first rising edge that sees busy low
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // leaves cluster in a small window so queries keep hitting written data,
  // with the two ends of the tree and the whole index range mixed in
  function automatic logic [IDX_W-1:0] pick_leaf();
    int r;
    r = $urandom_range(99);
    if (r < 60) return IDX_W'(hot_base + $urandom_range(HOT_SPAN - 1));
    if (r < 70) return IDX_W'($urandom_range(7));
    if (r < 80) return IDX_W'(LEAVES - 1 - $urandom_range(7));
    return IDX_W'($urandom_range(LEAVES - 1));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return SENTINEL;
      3: return SENTINEL + 1;
      4: return SENTINEL - 1;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // fresh tree: leaves never written still read as minus infinity, not empty
    send_command(OP_QUERY, 16'h0000, 16'hffff, '0);
    send_command(OP_QUERY, 16'h1234, 16'h1234, 32'shffffffff);
    // extreme values at the two ends of the tree; last index is ignored on a write
    send_command(OP_WRITE, 16'h0000, 16'hffff, 32'sh7fffffff);
    send_command(OP_WRITE, 16'hffff, 16'h0000, 32'sh80000000);
    send_command(OP_QUERY, 16'h0000, 16'h0000, '0);
    send_command(OP_QUERY, 16'hffff, 16'hffff, '0);
    send_command(OP_QUERY, 16'h0000, 16'hffff, '0);
    send_command(OP_QUERY, 16'h0001, 16'hffff, '0);
    // reversed ranges answer empty
    send_command(OP_QUERY, 16'h0005, 16'h0004, '0);
    send_command(OP_QUERY, 16'hffff, 16'h0000, '0);
    send_command(OP_QUERY, 16'hffff, 16'hfffe, '0);
    // values below minus infinity are kept but lose to the sentinel accumulator
    send_command(OP_WRITE, 16'd100, 16'd0, -32'sd2000000000);
    send_command(OP_QUERY, 16'd100, 16'd100, '0);
    send_command(OP_WRITE, 16'd101, 16'd0, SENTINEL);
    send_command(OP_WRITE, 16'd102, 16'd0, SENTINEL + 1);
    send_command(OP_QUERY, 16'd100, 16'd102, '0);
    // alternating bit patterns on every field
    send_command(OP_WRITE, 16'h5555, 16'haaaa, 32'sh55555555);
    send_command(OP_WRITE, 16'haaaa, 16'h5555, 32'shaaaaaaaa);
    send_command(OP_QUERY, 16'h5555, 16'haaaa, '1);
    send_command(OP_QUERY, 16'haaaa, 16'haaaa, '0);
    // overwrite lowers a maximum, the ancestors must follow it down
    send_command(OP_WRITE, 16'h0000, 16'h0000, 32'sd0);
    send_command(OP_QUERY, 16'h0000, 16'h0fff, '0);
    send_command(OP_QUERY, 16'h0000, 16'hffff, '0);
    send_command(OP_WRITE, 16'h5555, 16'h0000, 32'sd0);
    send_command(OP_QUERY, 16'h0001, 16'hfffe, '0);
  endtask

  // mixed writes and queries with the sender gap set by pct
  task automatic test_random_traffic(int count, int pct);
    logic                    op;
    logic [IDX_W-1:0]        first;
    logic [IDX_W-1:0]        last;
    logic signed [VAL_W-1:0] value;
    int                      r;
    int                      span;
    idle_pct = pct;
    hot_base = $urandom_range(LEAVES - HOT_SPAN);
    for (int i = 0; i < count; i++) begin
      // move the hot window now and then
      if ($urandom_range(63) == 0) hot_base = $urandom_range(LEAVES - HOT_SPAN);
      op = ($urandom_range(99) < 45) ? OP_QUERY : OP_WRITE;
      first = pick_leaf();
      last = IDX_W'($urandom);
      value = pick_value();
      if (op == OP_QUERY) begin
        r = $urandom_range(99);
        if (r < 65) begin
          // short range, clipped at the last leaf
          span = $urandom_range(40);
          last = (int'(first) + span > LEAVES - 1) ? IDX_W'(LEAVES - 1)
               : first + IDX_W'(span);
        end else if (r < 75) begin
          // reversed range
          if (first == 0) first = IDX_W'($urandom_range(LEAVES - 1, 1));
          last = first - IDX_W'(1) - IDX_W'($urandom_range(int'(first) - 1));
        end else if (r < 85) begin
          last = IDX_W'(LEAVES - 1);
        end else if (r < 90) begin
          first = '0;
        end
        // the rest keeps a fully random last index
      end
      send_command(op, first, last, value);
    end
  endtask

  // stop sending, wait for every answer owed, then let the back end settle
  task automatic wait_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    op_i          = OP_WRITE;
    first_index_i = '0;
    last_index_i  = '0;
    new_value_i   = '0;
    error_count   = 0;
    write_count   = 0;
    query_count   = 0;
    empty_count   = 0;
    answer_count  = 0;
    quiet_cycles  = 0;
    idle_pct      = 0;
    hot_base      = 0;
    clear_tree();
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // busy covers the clearing pass, so the first command simply waits on it
    test_directed();
    test_random_traffic(RANDOM_PER_PHASE, 0);
    test_random_traffic(RANDOM_PER_PHASE, 58);
    test_random_traffic(RANDOM_PER_PHASE, 7);
    wait_drained();

    $display("run covered %0d writes and %0d range queries, %0d of them empty ranges,",
             write_count, query_count, empty_count);
    $display("with %0d answers checked against the mirrored tree", answer_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[range_max_segment_tree.f]
rtl/core/rmst_pkg.sv
rtl/core/rmst_front.sv
rtl/core/rmst_queue.sv
rtl/core/rmst_back.sv
rtl/core/range_max_segment_tree.sv
test/range_max_segment_tree_tb.sv
